>>> rtl/lmcf_pkg.sv
package lmcf_pkg;

  // Matrix geometry
  localparam int unsigned ROWS = 8;
  localparam int unsigned RowW = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Driver register addresses
  localparam logic [3:0] AddrDecode    = 4'h9;
  localparam logic [3:0] AddrIntensity = 4'hA;
  localparam logic [3:0] AddrScan      = 4'hB;
  localparam logic [3:0] AddrShutdown  = 4'hC;
  localparam logic [3:0] AddrTest      = 4'hF;

  localparam int unsigned PcW = 4;

  typedef enum logic [2:0] {
    OpInit       = 3'd0,
    OpSetLed     = 3'd1,
    OpSetRow     = 3'd2,
    OpClear      = 3'd3,
    OpBrightness = 3'd4,
    OpShutStop   = 3'd5,
    OpTestStop   = 3'd6,
    OpNone       = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    AselConst  = 2'd0,
    AselRowIn  = 2'd1,
    AselRowCnt = 2'd2
  } addr_sel_e;

  typedef enum logic [1:0] {
    DselConst  = 2'd0,
    DselLed    = 2'd1,
    DselValue  = 2'd2,
    DselNibble = 2'd3
  } data_sel_e;

  // One control word of the sequencer program
  typedef struct packed {
    addr_sel_e  addr_sel;
    data_sel_e  data_sel;
    logic [3:0] addr;
    logic [7:0] data;
    logic       shadow_wr;  // write frame data back to the addressed row
    logic       row_loop;   // repeat over all rows, clearing each
    logic       last;       // end of program
  } ctrl_word_t;

  // Program entry points
  localparam logic [PcW-1:0] PcInit       = 4'd0;
  localparam logic [PcW-1:0] PcSetLed     = 4'd6;
  localparam logic [PcW-1:0] PcSetRow     = 4'd7;
  localparam logic [PcW-1:0] PcClear      = 4'd8;
  localparam logic [PcW-1:0] PcBrightness = 4'd9;
  localparam logic [PcW-1:0] PcShutStop   = 4'd10;
  localparam logic [PcW-1:0] PcTestStop   = 4'd11;
  localparam logic [PcW-1:0] PcLastStep   = 4'd11;

  function automatic ctrl_word_t cw(addr_sel_e as, data_sel_e ds, logic [3:0] a,
                                    logic [7:0] d, logic wr, logic lp, logic lst);
    ctrl_word_t w;
    w.addr_sel  = as;
    w.data_sel  = ds;
    w.addr      = a;
    w.data      = d;
    w.shadow_wr = wr;
    w.row_loop  = lp;
    w.last      = lst;
    return w;
  endfunction

  function automatic ctrl_word_t prog_rom(logic [PcW-1:0] pc);
    ctrl_word_t w;
    case (pc)
      4'd0:    w = cw(AselConst, DselConst, AddrScan, 8'(ROWS - 1), 1'b0, 1'b0, 1'b0);
      4'd1:    w = cw(AselConst, DselConst, AddrDecode, 8'h00, 1'b0, 1'b0, 1'b0);
      4'd2:    w = cw(AselConst, DselConst, AddrShutdown, 8'h01, 1'b0, 1'b0, 1'b0);
      4'd3:    w = cw(AselConst, DselConst, AddrTest, 8'h00, 1'b0, 1'b0, 1'b0);
      4'd4:    w = cw(AselRowCnt, DselConst, 4'h0, 8'h00, 1'b0, 1'b1, 1'b0);
      4'd5:    w = cw(AselConst, DselConst, AddrIntensity, 8'h0F, 1'b0, 1'b0, 1'b1);
      4'd6:    w = cw(AselRowIn, DselLed, 4'h0, 8'h00, 1'b1, 1'b0, 1'b1);
      4'd7:    w = cw(AselRowIn, DselValue, 4'h0, 8'h00, 1'b1, 1'b0, 1'b1);
      4'd8:    w = cw(AselRowCnt, DselConst, 4'h0, 8'h00, 1'b0, 1'b1, 1'b1);
      4'd9:    w = cw(AselConst, DselNibble, AddrIntensity, 8'h00, 1'b0, 1'b0, 1'b1);
      4'd10:   w = cw(AselConst, DselConst, AddrShutdown, 8'h01, 1'b0, 1'b0, 1'b1);
      4'd11:   w = cw(AselConst, DselConst, AddrTest, 8'h00, 1'b0, 1'b0, 1'b1);
      default: w = cw(AselConst, DselConst, 4'h0, 8'h00, 1'b0, 1'b0, 1'b1);
    endcase
    return w;
  endfunction

  // Shadow write command
  typedef struct packed {
    logic            en;
    logic [RowW-1:0] idx;
    logic [7:0]      data;
  } shadow_wr_t;

endpackage

>>> rtl/lmcf_shadow.sv
module lmcf_shadow (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lmcf_pkg::shadow_wr_t        wr_i,
  input  logic [lmcf_pkg::RowW-1:0]   rd_idx_i,
  output logic [7:0]                  rd_data_o
);

  logic [7:0] rows_q [lmcf_pkg::ROWS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(lmcf_pkg::ROWS); i++) begin
        rows_q[i] <= 8'h00;
      end
    end else if (wr_i.en) begin
      rows_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign rd_data_o = rows_q[rd_idx_i];

endmodule

>>> rtl/led_matrix_command_framer.sv
// LED matrix command framer.
// Slave stream s_axis_* takes one command word; master stream m_axis_* gives
// one driver frame (register address, data byte) per word, tlast on the last
// frame of a command. A small program ROM steps through each command's frames,
// one control word per frame; a row loop step repeats over the matrix rows.
// Frame counts: init 4 + ROWS + 1, clear ROWS, every other command 1, and a
// command with a row or column out of range (or the unused opcode) none.
// After a command is taken, its frames are loaded into the output register;
// with the receiver ready, frames follow one per cycle. A new command is taken
// in the cycle after the last frame is loaded into the output register; an
// empty command is dropped and the slave stream stays ready for the next.
// The output register holds its frame while m_axis_tready_i is low and the
// sequencer waits on it. Reset clears the shadow rows, empties the output
// register and idles the sequencer.
module led_matrix_command_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] op, [6:3] row, [10:7] col, [11] led_on, [19:12] value, [23:20] zero
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] reg_addr, [11:4] reg_data, [15:12] zero
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  logic                          busy_q, busy_d;
  logic [lmcf_pkg::PcW-1:0]      pc_q, pc_d;
  logic [lmcf_pkg::RowW-1:0]     rc_q, rc_d;
  logic [3:0]                    row_q, col_q;
  logic                          led_on_q;
  logic [7:0]                    value_q;
  logic                          out_valid_q, out_valid_d;
  logic [3:0]                    out_addr_q;
  logic [7:0]                    out_data_q;
  logic                          out_last_q;

  lmcf_pkg::ctrl_word_t      cword;
  lmcf_pkg::shadow_wr_t      shadow_wr;
  logic [7:0]                shadow_rd;
  logic                      in_fire, step_en, rc_end, last_frame, cmd_ok;
  logic [lmcf_pkg::PcW-1:0]  entry_pc;
  logic [3:0]                in_row, in_col, frame_addr;
  logic [2:0]                in_op;
  logic [7:0]                frame_data, led_bit;

  assign in_op  = s_axis_tdata_i[2:0];
  assign in_row = s_axis_tdata_i[6:3];
  assign in_col = s_axis_tdata_i[10:7];

  assign s_axis_tready_o = !busy_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Decode entry point; drop commands that emit nothing
  always_comb begin
    entry_pc = lmcf_pkg::PcInit;
    cmd_ok   = 1'b1;
    case (lmcf_pkg::op_e'(in_op))
      lmcf_pkg::OpInit:       entry_pc = lmcf_pkg::PcInit;
      lmcf_pkg::OpSetLed: begin
        entry_pc = lmcf_pkg::PcSetLed;
        cmd_ok   = (in_row < 4'(lmcf_pkg::ROWS)) && !in_col[3];
      end
      lmcf_pkg::OpSetRow: begin
        entry_pc = lmcf_pkg::PcSetRow;
        cmd_ok   = in_row < 4'(lmcf_pkg::ROWS);
      end
      lmcf_pkg::OpClear:      entry_pc = lmcf_pkg::PcClear;
      lmcf_pkg::OpBrightness: entry_pc = lmcf_pkg::PcBrightness;
      lmcf_pkg::OpShutStop:   entry_pc = lmcf_pkg::PcShutStop;
      lmcf_pkg::OpTestStop:   entry_pc = lmcf_pkg::PcTestStop;
      default:                cmd_ok   = 1'b0;
    endcase
  end

  assign cword      = lmcf_pkg::prog_rom(pc_q);
  assign step_en    = busy_q && (!out_valid_q || m_axis_tready_i);
  assign rc_end     = rc_q == lmcf_pkg::RowW'(lmcf_pkg::ROWS - 1);
  assign last_frame = cword.last && (!cword.row_loop || rc_end);
  assign led_bit    = 8'h80 >> col_q[2:0];

  lmcf_shadow u_shadow (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (shadow_wr),
    .rd_idx_i  (row_q[lmcf_pkg::RowW-1:0]),
    .rd_data_o (shadow_rd)
  );

  // Datapath: frame address and data from the current control word
  always_comb begin
    case (cword.addr_sel)
      lmcf_pkg::AselConst:  frame_addr = cword.addr;
      lmcf_pkg::AselRowIn:  frame_addr = row_q + 4'd1;
      lmcf_pkg::AselRowCnt: frame_addr = 4'(rc_q) + 4'd1;
      default:              frame_addr = cword.addr;
    endcase
    case (cword.data_sel)
      lmcf_pkg::DselConst:  frame_data = cword.data;
      lmcf_pkg::DselLed:    frame_data = led_on_q ? (shadow_rd | led_bit)
                                                  : (shadow_rd & ~led_bit);
      lmcf_pkg::DselValue:  frame_data = value_q;
      lmcf_pkg::DselNibble: frame_data = {4'h0, value_q[3:0]};
      default:              frame_data = cword.data;
    endcase
  end

  always_comb begin
    shadow_wr.en   = step_en && (cword.shadow_wr || cword.row_loop);
    shadow_wr.idx  = cword.row_loop ? rc_q : row_q[lmcf_pkg::RowW-1:0];
    shadow_wr.data = cword.row_loop ? 8'h00 : frame_data;
  end

  // Sequencer
  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    rc_d        = rc_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      busy_d = cmd_ok;
      pc_d   = entry_pc;
      rc_d   = '0;
    end else if (step_en) begin
      out_valid_d = 1'b1;
      if (cword.row_loop && !rc_end) begin
        rc_d = rc_q + lmcf_pkg::RowW'(1);
      end else begin
        rc_d = '0;
        pc_d = pc_q + lmcf_pkg::PcW'(1);
      end
      if (last_frame) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      rc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      rc_q        <= rc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      row_q    <= in_row;
      col_q    <= in_col;
      led_on_q <= s_axis_tdata_i[11];
      value_q  <= s_axis_tdata_i[19:12];
    end
    if (step_en) begin
      out_addr_q <= frame_addr;
      out_data_q <= frame_data;
      out_last_q <= last_frame;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'h0, out_data_q, out_addr_q};
  assign m_axis_tlast_o  = out_last_q;

  // Last step of a program returns the sequencer to idle
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en && last_frame |=> !busy_q)
    else $error("sequencer still busy after last frame");

  // Row counter only moves inside a row loop
  a_rc_in_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q != '0 |-> busy_q && cword.row_loop)
    else $error("row counter active outside row loop");

  // Program counter stays inside the program while busy
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc_q <= lmcf_pkg::PcLastStep)
    else $error("program counter out of range");

endmodule
